FILE: rtl/core/sem_pkg.sv
// Shared types, codes and constants for the sorted extent map.
`default_nettype none
package sem_pkg;
  localparam int unsigned MaxExtentsDef = 64;
  localparam logic [21:0] ClusterBytesRst = 22'd4096;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_RANGE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INSERTED   = 4'd0,
    ST_NAMED      = 4'd1,
    ST_INVERTED   = 4'd2,
    ST_MISMATCH   = 4'd3,
    ST_OVERLAP    = 4'd4,
    ST_FULL       = 4'd5,
    ST_FOUND      = 4'd6,
    ST_NOT_FOUND  = 4'd7,
    ST_MAPPED     = 4'd8,
    ST_NOT_MAPPED = 4'd9
  } status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] start_cluster;
    logic [63:0] last_cluster;
    logic        is_named;
    logic        check_expected;
    logic [63:0] expected_start;
    logic [15:0] extent_handle;
    logic [63:0] query_cluster;
    logic [63:0] byte_offset;
    logic [63:0] byte_length;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] hit_handle;
    logic [63:0] hit_start;
    logic [63:0] hit_last;
  } out_word_t;

  localparam int unsigned CfgClusterBytes = 0;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input word
    logic scan_clr;    // reset scan index
    logic scan_rd;     // issue read at scan index
    logic scan_cap;    // compare registered read data, advance
    logic shift_rd;    // read entry at shift index
    logic shift_wr;    // write read data one slot up, step down
    logic ins_wr;      // write new entry at position
    logic div_start;   // start cur / cb
    logic walk_next;   // cur <- (last+1)*cb
    logic mul_start;
    logic emit;
  } sem_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;   // upper position found
    logic shift_done;
    logic div_done;
    logic mul_done;
    logic walk_mapped; // cur >= end
    logic cover_hit;
    logic ins_reject;  // static reject or overlap or full
    logic walk_limit;
    logic range_trivial;
  } sem_stat_t;
endpackage
`default_nettype wire

FILE: rtl/core/sem_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module sem_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/sem_ctrl.sv
// Sequencing state machine of the sorted extent map.
`default_nettype none
module sem_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        cmd,
  input  wire sem_pkg::sem_stat_t st,
  output sem_pkg::sem_cmd_t      ctl,
  output logic                   busy
);
  import sem_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCANRD = 9'b000000010,
    S_SCANCP = 9'b000000100,
    S_SHRD   = 9'b000001000,
    S_SHWR   = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_MUL    = 9'b001000000,
    S_DONE   = 9'b010000000,
    S_DECIDE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] cmd_r, cmd_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          ctl.scan_clr = 1'b1;
          cmd_nxt = cmd;
          unique case (cmd_t'(cmd))
            CMD_INSERT, CMD_FIND: state_nxt = S_SCANRD;
            CMD_RANGE: state_nxt = S_DECIDE;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_DECIDE: begin
        if (st.range_trivial || st.walk_mapped || st.walk_limit) begin
          state_nxt = S_DONE;
        end else begin
          ctl.div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          ctl.scan_clr = 1'b1;
          state_nxt = S_SCANRD;
        end
      end
      S_SCANRD: begin
        if (st.scan_done) begin
          state_nxt = S_DONE;
          if (cmd_t'(cmd_r) == CMD_INSERT) begin
            if (!st.ins_reject) state_nxt = S_SHRD;
          end else if (cmd_t'(cmd_r) == CMD_RANGE) begin
            if (st.cover_hit) begin
              ctl.mul_start = 1'b1;
              state_nxt = S_MUL;
            end
          end
        end else begin
          ctl.scan_rd = 1'b1;
          state_nxt = S_SCANCP;
        end
      end
      S_SCANCP: begin
        ctl.scan_cap = 1'b1;
        state_nxt = S_SCANRD;
      end
      S_MUL: begin
        if (st.mul_done) begin
          ctl.walk_next = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_SHRD: begin
        if (st.shift_done) begin
          ctl.ins_wr = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ctl.shift_rd = 1'b1;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        ctl.shift_wr = 1'b1;
        state_nxt = S_SHRD;
      end
      S_DONE: begin
        ctl.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cmd_r <= cmd_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

`ifndef SYNTH
  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> !ctl.emit) else $error("double emit");
  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> !busy) else $error("not idle after emit");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> !busy) else $error("load while busy");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/sem_dp.sv
// Datapath of the sorted extent map: entry memories, scan, shift, divider, multiplier.
`default_nettype none
module sem_dp #(
  parameter int unsigned MaxExtents = sem_pkg::MaxExtentsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sem_pkg::in_word_t  in_word,
  input  wire logic [21:0]        cluster_bytes,
  input  wire sem_pkg::sem_cmd_t  ctl,
  output sem_pkg::sem_stat_t      st,
  output sem_pkg::out_word_t      out_word,
  output logic                    out_valid
);
  import sem_pkg::*;

  localparam int unsigned AW = $clog2(MaxExtents);
  localparam int unsigned CW = $clog2(MaxExtents + 1);
  localparam int unsigned SW = $clog2(MaxExtents + 2);

  in_word_t   w_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;      // scan position / shift index
  logic          found_r, found_nxt;  // scan stopped on start > key
  logic [63:0]   nstart_r, nstart_nxt; // start at upper pos
  logic [63:0]   pstart_r, plast_r;
  logic [15:0]   phandle_r;
  logic [63:0]   pstart_nxt, plast_nxt;
  logic [15:0]   phandle_nxt;
  logic          pvalid_r, pvalid_nxt;
  logic [63:0]   cur_r, cur_nxt, end_r, end_nxt, key_r, key_nxt;
  logic [SW-1:0] steps_r, steps_nxt;

  // memories
  logic          we;
  logic [AW-1:0] addr;
  logic [63:0]   wd_s, wd_l, rd_s, rd_l;
  logic [15:0]   wd_h, rd_h;

  sem_ram #(.Width(64), .Depth(MaxExtents)) u_start (.clk(clk), .we(we), .addr(addr),
    .wdata(wd_s), .rdata(rd_s));
  sem_ram #(.Width(64), .Depth(MaxExtents)) u_last (.clk(clk), .we(we), .addr(addr),
    .wdata(wd_l), .rdata(rd_l));
  sem_ram #(.Width(16), .Depth(MaxExtents)) u_hdl (.clk(clk), .we(we), .addr(addr),
    .wdata(wd_h), .rdata(rd_h));

  // divider: cur / cb, restoring, one bit per cycle
  logic [63:0] q_r, q_nxt;
  logic [22:0] rem_r, rem_nxt;
  logic [6:0]  dcnt_r, dcnt_nxt;
  logic        dbusy_r, dbusy_nxt;
  logic [22:0] rtry;
  // multiplier: (last+1)*cb, shift-add one bit per cycle
  logic [63:0] macc_r, macc_nxt, mcand_r, mcand_nxt;
  logic [21:0] mplier_r, mplier_nxt;
  logic        mbusy_r, mbusy_nxt;

  logic [63:0] key;
  logic        static_rej;
  logic        ovl_prev, ovl_next, full;

  assign key = (cmd_t'(w_r.cmd) == CMD_INSERT) ? w_r.start_cluster : key_r;
  assign static_rej = w_r.is_named || (w_r.start_cluster > w_r.last_cluster) ||
    (w_r.check_expected && (w_r.start_cluster != w_r.expected_start));
  assign ovl_prev = pvalid_r && (plast_r >= w_r.start_cluster);
  assign ovl_next = found_r && (nstart_r <= w_r.last_cluster);
  assign full = (count_r >= CW'(MaxExtents));

  always_comb begin
    st = '0;
    st.scan_done = found_r || (idx_r == count_r);
    st.shift_done = (idx_r == CW'(0)) || (idx_r == key_r[CW-1:0]);
    st.div_done = !dbusy_r;
    st.mul_done = !mbusy_r;
    st.walk_mapped = !(cur_r < end_r);
    st.cover_hit = pvalid_r && (plast_r >= key_r);
    st.ins_reject = static_rej || ovl_prev || ovl_next || full;
    st.walk_limit = (steps_r > SW'(MaxExtents));
    st.range_trivial = (cluster_bytes == 22'd0) || (w_r.byte_length == 64'd0);
  end

  assign rtry = {rem_r[21:0], q_r[63]} - {1'b0, cluster_bytes};

  always_comb begin
    count_nxt = count_r;
    idx_nxt = idx_r;
    found_nxt = found_r;
    nstart_nxt = nstart_r;
    pstart_nxt = pstart_r;
    plast_nxt = plast_r;
    phandle_nxt = phandle_r;
    pvalid_nxt = pvalid_r;
    cur_nxt = cur_r;
    end_nxt = end_r;
    key_nxt = key_r;
    steps_nxt = steps_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    dcnt_nxt = dcnt_r;
    dbusy_nxt = dbusy_r;
    macc_nxt = macc_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    mbusy_nxt = mbusy_r;
    we = 1'b0;
    addr = idx_r[AW-1:0];
    wd_s = rd_s;
    wd_l = rd_l;
    wd_h = rd_h;

    if (ctl.load) begin
      cur_nxt = in_word.byte_offset;
      end_nxt = in_word.byte_offset + in_word.byte_length;
      key_nxt = in_word.query_cluster;
      steps_nxt = '0;
    end
    if (ctl.scan_clr) begin
      idx_nxt = '0;
      found_nxt = 1'b0;
      pvalid_nxt = 1'b0;
    end
    if (ctl.scan_cap) begin
      if (rd_s <= key) begin
        pstart_nxt = rd_s;
        plast_nxt = rd_l;
        phandle_nxt = rd_h;
        pvalid_nxt = 1'b1;
        idx_nxt = idx_r + CW'(1);
      end else begin
        found_nxt = 1'b1;
        nstart_nxt = rd_s;
      end
    end
    // insert: after scan, idx_r holds the position; stash it in key_r, walk idx from count
    if (!ctl.scan_cap && !ctl.scan_rd && !ctl.shift_rd && !ctl.shift_wr && !ctl.ins_wr &&
        st.scan_done && cmd_t'(w_r.cmd) == CMD_INSERT && !ctl.load && !ctl.emit &&
        !st.ins_reject && idx_r != count_r + CW'(0) && 1'b0) begin
      idx_nxt = idx_r;
    end
    if (ctl.shift_rd) begin
      addr = AW'(idx_r - CW'(1));
    end
    if (ctl.shift_wr) begin
      we = 1'b1;
      idx_nxt = idx_r - CW'(1);
    end
    if (ctl.ins_wr) begin
      we = 1'b1;
      wd_s = w_r.start_cluster;
      wd_l = w_r.last_cluster;
      wd_h = w_r.extent_handle;
      count_nxt = count_r + CW'(1);
    end
    if (ctl.div_start) begin
      q_nxt = cur_r;
      rem_nxt = '0;
      dcnt_nxt = 7'd64;
      dbusy_nxt = 1'b1;
      steps_nxt = steps_r + SW'(1);
    end else if (dbusy_r) begin
      if (!rtry[22]) begin
        rem_nxt = rtry;
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[21:0], q_r[63]};
        q_nxt = {q_r[62:0], 1'b0};
      end
      dcnt_nxt = dcnt_r - 7'd1;
      if (dcnt_r == 7'd1) begin
        dbusy_nxt = 1'b0;
      end
    end
    if (dbusy_r && dcnt_r == 7'd1) begin
      key_nxt = rtry[22] ? {q_r[62:0], 1'b0} : {q_r[62:0], 1'b1};
    end
    if (ctl.mul_start) begin
      macc_nxt = '0;
      mcand_nxt = plast_r + 64'd1;
      mplier_nxt = cluster_bytes;
      mbusy_nxt = 1'b1;
    end else if (mbusy_r) begin
      if (mplier_r[0]) macc_nxt = macc_r + mcand_r;
      mcand_nxt = {mcand_r[62:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[21:1]};
      if (mplier_r[21:1] == 21'd0) mbusy_nxt = 1'b0;
    end
    if (ctl.walk_next) begin
      cur_nxt = macc_r;
    end
  end

  // insert shift phase: position held in posn_r, shift index counts down from count
  logic [CW-1:0] posn_r;
  logic          shmode_r;

  // output formation
  out_word_t ow;
  always_comb begin
    ow = '0;
    unique case (cmd_t'(w_r.cmd))
      CMD_INSERT: begin
        priority if (w_r.is_named) ow.status = ST_NAMED;
        else if (w_r.start_cluster > w_r.last_cluster) ow.status = ST_INVERTED;
        else if (w_r.check_expected && (w_r.start_cluster != w_r.expected_start))
          ow.status = ST_MISMATCH;
        else if (ovl_prev || ovl_next) ow.status = ST_OVERLAP;
        else if (shmode_r) ow.status = ST_INSERTED;
        else ow.status = ST_FULL;
      end
      CMD_FIND: begin
        if (pvalid_r && plast_r >= key_r) begin
          ow.status = ST_FOUND;
          ow.hit_handle = phandle_r;
          ow.hit_start = pstart_r;
          ow.hit_last = plast_r;
        end else begin
          ow.status = ST_NOT_FOUND;
        end
      end
      CMD_RANGE: begin
        if (st.range_trivial) ow.status = ST_NOT_MAPPED;
        else if (end_r < w_r.byte_offset) ow.status = ST_MAPPED;
        else if (!(cur_r < end_r) && !st.walk_limit && steps_r != SW'(0) &&
                 pvalid_r && plast_r >= key_r) ow.status = ST_MAPPED;
        else ow.status = ST_NOT_MAPPED;
      end
      default: ow.status = ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      dbusy_r <= 1'b0;
      mbusy_r <= 1'b0;
      out_valid <= 1'b0;
      shmode_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      dbusy_r <= dbusy_nxt;
      mbusy_r <= mbusy_nxt;
      out_valid <= ctl.emit;
      if (ctl.load) shmode_r <= 1'b0;
      if (ctl.ins_wr) shmode_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) w_r <= in_word;
    found_r <= found_nxt;
    nstart_r <= nstart_nxt;
    pstart_r <= pstart_nxt;
    plast_r <= plast_nxt;
    phandle_r <= phandle_nxt;
    pvalid_r <= pvalid_nxt;
    cur_r <= cur_nxt;
    end_r <= end_nxt;
    steps_r <= steps_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    macc_r <= macc_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
    if (ctl.emit) out_word <= ow;
    // after scan of an insert, move idx to count and remember position
    if (cmd_t'(w_r.cmd) == CMD_INSERT && st.scan_done && !shmode_r && !ctl.shift_rd &&
        !ctl.shift_wr && !ctl.scan_rd && !ctl.scan_cap && posn_r == '1 && !ctl.load) begin
      posn_r <= idx_r;
      idx_r <= count_r;
      key_r <= {{(64-CW){1'b0}}, idx_r};
    end else begin
      if (ctl.load) posn_r <= '1;
      idx_r <= idx_nxt;
      key_r <= (ctl.ins_wr) ? key_r : key_nxt;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MaxExtents)) else $error("count overflow");
  a_ins_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_wr |=> count_r == $past(count_r) + CW'(1)) else $error("count step");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.div_start |-> !dbusy_r) else $error("divider restart");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/sorted_extent_map_unit.sv
// Top level of the sorted extent map: APB register, controller and datapath.
// One command at a time: assert start while busy is low; exactly one result
// appears on out_* with out_valid high for one cycle, which the receiver must
// take. Find scans the stored extents in order up to the first start above
// the key (one memory read and compare per entry). Insert also shifts each
// later entry up one slot. Range check does a divide, a scan and a multiply
// per covered extent, at most MAX_EXTENTS+1. Stored entries need no clear.
`default_nettype none
module sorted_extent_map_unit #(
  parameter int unsigned MAX_EXTENTS = sem_pkg::MaxExtentsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire sem_pkg::in_word_t  in_word,
  output logic                    out_valid,
  output sem_pkg::out_word_t      out_word,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic               paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import sem_pkg::*;

  logic [21:0] cb_r;
  sem_cmd_t ctl;
  sem_stat_t st;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {10'd0, cb_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_r <= ClusterBytesRst;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      cb_r <= pwdata[21:0];
    end
  end

  sem_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .cmd(in_word.cmd),
    .st(st), .ctl(ctl), .busy(busy));

  sem_dp #(.MaxExtents(MAX_EXTENTS)) u_dp (.clk(clk), .rst_n(rst_n), .in_word(in_word),
    .cluster_bytes(cb_r), .ctl(ctl), .st(st), .out_word(out_word), .out_valid(out_valid));
endmodule
`default_nettype wire
